[rtl/hmt_pkg.sv]
// Package for the heartbeat membership table: word types, sizes and codes.
// No dependencies.
package hmt_pkg;

    localparam int MaxMembers = 32;
    localparam int IdxW = $clog2(MaxMembers);
    localparam int CntW = $clog2(MaxMembers + 1);

    localparam logic [15:0] FailTimeoutReset = 16'd5;
    localparam logic [15:0] RemoveTimeoutReset = 16'd20;

    localparam logic CfgFailTimeout = 1'b0;
    localparam logic CfgRemoveTimeout = 1'b1;

    localparam logic KindUpdate = 1'b0;
    localparam logic KindSweep = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] member_id;
        logic [15:0] member_port;
        logic [31:0] member_heartbeat;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic        added;
        logic        table_full;
        logic        removed_valid;
        logic [31:0] removed_id;
        logic [15:0] removed_port;
        logic [5:0]  failed_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [31:0] node;
        logic [15:0] port_no;
        logic [31:0] beat;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD_DONE,
        ST_OUT,
        ST_SUMMARY
    } state_t;

endpackage

[rtl/heartbeat_membership_table.sv]
// Heartbeat membership table: 32-entry member table with update and timeout sweep.
// An item walks all entries through a registered-read memory, one entry per cycle while no removal word waits.
// An update gives one result word; a sweep gives a word per removed member, then a summary.
// One item at a time; the next is taken once the last word has been delivered.
// Reset (synchronous, active low) clears all valid marks and restores the timeouts.
module heartbeat_membership_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  hmt_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hmt_pkg::out_word_t m_data
);
    import hmt_pkg::*;

    logic [15:0] fail_to_reg, remove_to_reg;
    logic [MaxMembers-1:0] valid_reg, valid_next;
    state_t state_reg, state_next;
    in_word_t item_reg, item_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [IdxW-1:0] rd_idx_reg;
    logic rd_en_reg;
    logic hit_reg, hit_next, free_reg, free_next;
    logic [IdxW-1:0] hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    logic [5:0] failed_reg, failed_next;
    out_word_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic [CntW-1:0] fetch_idx;
    logic fetch_en;
    logic we;
    logic [IdxW-1:0] waddr;
    entry_t wdata, rdata;
    logic [31:0] idle;

    hmt_entry_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(fetch_idx[IdxW-1:0]), .rdata(rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;
    assign idle = item_reg.now - rdata.stamp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_to_reg <= FailTimeoutReset;
            remove_to_reg <= RemoveTimeoutReset;
            valid_reg <= '0;
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rd_en_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CfgFailTimeout: fail_to_reg <= cfg_data;
                    CfgRemoveTimeout: remove_to_reg <= cfg_data;
                endcase
            end
            valid_reg <= valid_next;
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            rd_en_reg <= fetch_en;
        end
        item_reg <= item_next;
        idx_reg <= idx_next;
        rd_idx_reg <= fetch_idx[IdxW-1:0];
        hit_reg <= hit_next;
        free_reg <= free_next;
        hit_idx_reg <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        failed_reg <= failed_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        item_next = item_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        free_next = free_reg;
        hit_idx_next = hit_idx_reg;
        free_idx_next = free_idx_reg;
        failed_next = failed_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        fetch_idx = idx_reg;
        fetch_en = 1'b0;
        we = 1'b0;
        waddr = hit_idx_reg;
        wdata = '{node: item_reg.member_id, port_no: item_reg.member_port,
                  beat: item_reg.member_heartbeat, stamp: item_reg.now};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    idx_next = '0;
                    hit_next = 1'b0;
                    free_next = 1'b0;
                    failed_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the read for idx_reg; evaluate the entry fetched last cycle.
                if (idx_reg < CntW'(MaxMembers)) begin
                    fetch_en = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_en_reg && valid_reg[rd_idx_reg]) begin
                    if (item_reg.kind == KindUpdate) begin
                        if (!hit_reg && rdata.node == item_reg.member_id
                                && rdata.port_no == item_reg.member_port) begin
                            hit_next = 1'b1;
                            hit_idx_next = rd_idx_reg;
                            if (rdata.beat < item_reg.member_heartbeat) begin
                                we = 1'b1;
                                waddr = rd_idx_reg;
                                wdata.node = rdata.node;
                                wdata.port_no = rdata.port_no;
                            end
                        end
                    end else if (idle >= {16'd0, fail_to_reg}) begin
                        failed_next = failed_reg + 1'b1;
                        if (idle >= {16'd0, remove_to_reg}) begin
                            valid_next[rd_idx_reg] = 1'b0;
                            idx_next = idx_reg;
                            out_next = '0;
                            out_next.removed_valid = 1'b1;
                            out_next.removed_id = rdata.node;
                            out_next.removed_port = rdata.port_no;
                            m_valid_next = 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                end else if (rd_en_reg && !free_reg) begin
                    free_next = 1'b1;
                    free_idx_next = rd_idx_reg;
                end
                if (!fetch_en && state_next == ST_SCAN) begin
                    state_next = (item_reg.kind == KindUpdate) ? ST_UPD_DONE : ST_SUMMARY;
                end
            end
            ST_OUT: begin
                // Hold the walk until the removal word is taken, then refetch.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_UPD_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = '0;
                    out_next.last = 1'b1;
                    if (!hit_reg) begin
                        if (free_reg) begin
                            we = 1'b1;
                            waddr = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            out_next.added = 1'b1;
                        end else begin
                            out_next.table_full = 1'b1;
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SUMMARY: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = '0;
                    out_next.failed_count = failed_reg;
                    out_next.last = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/hmt_entry_ram.sv]
// Entry memory of the membership table: one write port, one registered read port.
// Depends on hmt_pkg.
module hmt_entry_ram (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [hmt_pkg::IdxW-1:0] waddr,
    input  hmt_pkg::entry_t      wdata,
    input  logic [hmt_pkg::IdxW-1:0] raddr,
    output hmt_pkg::entry_t      rdata
);
    import hmt_pkg::*;

    entry_t mem [MaxMembers];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hmt_checker.sv]
// Port-level checker for the heartbeat membership table, bound to the top level.
// Depends on hmt_pkg and heartbeat_membership_table.
module hmt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input hmt_pkg::out_word_t m_data
);
    import hmt_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.added, m_data.table_full,
                                m_data.removed_valid}) <= 1)
        else $error("result word flags conflict");
    a_removal_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.removed_valid |-> !m_data.last)
        else $error("removal word marked last");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
